FILE: design/signed_radix_to_text_defines.svh
// Assertion macros used by the checker file of the text converter.
`ifndef SIGNED_RADIX_TO_TEXT_DEFINES_SVH
`define SIGNED_RADIX_TO_TEXT_DEFINES_SVH

`define SRTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srtt: same-cycle check failed");

`define SRTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srtt: next-cycle check failed");

`endif

FILE: design/srtt_pkg.sv
// Shared types and constants of the signed radix to text converter.
package srtt_pkg;

  localparam int unsigned SYM_W     = 8;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned RADIX_W   = 5;
  localparam int unsigned TAB_N     = 16;
  localparam int unsigned TAB_IDX_W = 4;
  localparam int unsigned CHUNK_W   = 8;

  typedef enum logic [1:0] {
    CFG_RADIX  = 2'd0,
    CFG_SYM_LO = 2'd1,
    CFG_SYM_HI = 2'd2
  } cfg_idx_e;

  localparam logic [SYM_W-1:0]   CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0]   CHAR_MINUS = 8'h2D;
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_RST  = 5'd16;
  localparam logic [CFG_W-1:0]   SYM_LO_RST = 64'h3736353433323130;
  localparam logic [CFG_W-1:0]   SYM_HI_RST = 64'h6665646362613938;

  typedef logic [TAB_N-1:0][SYM_W-1:0] sym_tab_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } srtt_cmd_t;

  typedef struct packed {
    logic digit_done;
    logic quot_zero;
    logic neg;
    logic last_digit;
    logic slot_free;
  } srtt_sts_t;

endpackage

FILE: design/signed_radix_to_text.sv
// Top level of the signed radix to text converter.
// Each input beat on the slave stream carries one signed integer; its low VALUE_BITS
// bits are converted to text and leave on the master stream as one character per
// beat: a leading '-' for a negative value, then the digits most significant first,
// with tlast on the final character. Digits are looked up in the configured alphabet
// of radix symbols. If the alphabet is invalid the beat is taken and nothing is sent.
// Configuration writes take effect at the clock edge of the write; the user must
// make them only while the block is idle, which the block itself does not enforce.
// For each digit the long divider divides the whole value by the radix, retiring
// eight quotient bits per cycle; each character then leaves through the output
// register, one per cycle while the receiver does not stall. The next item is taken
// while the last character still waits.
// When the receiver stalls, the output register holds its beat and the block waits.
// Reset loads radix 16 with alphabet "0123456789abcdef" and empties all stages.
module signed_radix_to_text import srtt_pkg::*; #(
  parameter int unsigned MAX_RADIX  = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [VAL_W-1:0] s_axis_tdata,   // value
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [SYM_W-1:0] m_axis_tdata,   // symbol
  output logic             m_axis_tlast,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [RADIX_W-1:0] radix;
  sym_tab_t           sym_tab;
  logic               alpha_ok;
  srtt_cmd_t          cmd;
  srtt_sts_t          sts;

  srtt_cfg #(
    .MAX_RADIX(MAX_RADIX)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .radix_o    (radix),
    .sym_tab_o  (sym_tab),
    .alpha_ok_o (alpha_ok)
  );

  srtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .alpha_ok_i (alpha_ok),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srtt_dp #(
    .MAX_RADIX (MAX_RADIX),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_axis_tdata),
    .radix_i     (radix),
    .sym_tab_i   (sym_tab),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_sym_o   (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: design/srtt_cfg.sv
// Configuration registers and alphabet validity check.
module srtt_cfg import srtt_pkg::*; #(
  parameter int unsigned MAX_RADIX = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  output logic [RADIX_W-1:0] radix_o,
  output sym_tab_t           sym_tab_o,
  output logic               alpha_ok_o
);

  logic [RADIX_W-1:0] radix_q;
  logic [CFG_W-1:0]   sym_lo_q;
  logic [CFG_W-1:0]   sym_hi_q;
  sym_tab_t           tab;
  logic               bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= RADIX_RST;
      sym_lo_q <= SYM_LO_RST;
      sym_hi_q <= SYM_HI_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RADIX:  radix_q  <= cfg_data_i[RADIX_W-1:0];
        CFG_SYM_LO: sym_lo_q <= cfg_data_i;
        CFG_SYM_HI: sym_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign tab = {sym_hi_q, sym_lo_q};

  always_comb begin
    bad = (radix_q < RADIX_MIN) || (radix_q > RADIX_W'(MAX_RADIX));
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (RADIX_W'(i) < radix_q) begin
        if (tab[i] == CHAR_PLUS || tab[i] == CHAR_MINUS) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if (RADIX_W'(j) < radix_q && tab[i] == tab[j]) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign radix_o    = radix_q;
  assign sym_tab_o  = tab;
  assign alpha_ok_o = !bad;

endmodule

FILE: design/srtt_ctrl.sv
// Controller state machine sequencing division and character output.
module srtt_ctrl import srtt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      alpha_ok_i,
  input  srtt_sts_t sts_i,
  output srtt_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_DIGITS
  } state_e;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && alpha_ok_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.digit_done && sts_i.quot_zero) begin
          state_d = sts_i.neg ? S_SIGN : S_DIGITS;
        end
      end
      S_SIGN: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.last_digit) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: design/srtt_dp.sv
// Datapath: chunked long division, digit stack and output register.
module srtt_dp import srtt_pkg::*; #(
  parameter int unsigned MAX_RADIX  = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [VAL_W-1:0]   value_i,
  input  logic [RADIX_W-1:0] radix_i,
  input  sym_tab_t           sym_tab_i,
  input  srtt_cmd_t          cmd_i,
  output srtt_sts_t          sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [SYM_W-1:0]   out_sym_o,
  output logic               out_last_o
);

  localparam int unsigned DigW  = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int unsigned RemW  = DigW + 1;
  localparam int unsigned Steps = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned PadW  = Steps * CHUNK_W;
  localparam int unsigned StepW = (Steps > 1) ? $clog2(Steps) : 1;
  localparam int unsigned CntW  = $clog2(VALUE_BITS + 1);

  logic [PadW-1:0]       work_q;
  logic [DigW-1:0]       rem_q;
  logic                  neg_q;
  logic [StepW-1:0]      step_q;
  logic [CntW-1:0]       cnt_q;
  logic [DigW-1:0]       stk_q [VALUE_BITS];
  logic                  out_valid_q;
  logic [SYM_W-1:0]      out_sym_q;
  logic                  out_last_q;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic [RemW-1:0]       divisor;
  logic [RemW-1:0]       trial;
  logic [RemW-1:0]       diff;
  logic [DigW-1:0]       rem_nx;
  logic [CHUNK_W-1:0]    quo;
  logic [PadW-1:0]       work_nx;
  logic                  digit_done;
  logic                  last_digit;
  logic                  slot_free;

  assign raw     = value_i[VALUE_BITS-1:0];
  assign mag     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign divisor = RemW'(radix_i);

  always_comb begin
    rem_nx = rem_q;
    quo    = '0;
    trial  = '0;
    diff   = '0;
    for (int k = 0; k < CHUNK_W; k++) begin
      trial = {rem_nx, work_q[PadW-1-k]};
      diff  = trial - divisor;
      if (trial >= divisor) begin
        quo[CHUNK_W-1-k] = 1'b1;
        rem_nx           = diff[DigW-1:0];
      end else begin
        rem_nx = trial[DigW-1:0];
      end
    end
  end

  assign work_nx    = PadW'({work_q, quo});
  assign digit_done = (step_q == StepW'(Steps - 1));
  assign last_digit = (cnt_q == CntW'(1));
  assign slot_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        step_q <= '0;
        cnt_q  <= '0;
      end else if (cmd_i.div_step) begin
        if (digit_done) begin
          step_q <= '0;
          cnt_q  <= cnt_q + 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end else if (cmd_i.emit_digit) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.emit_sign || cmd_i.emit_digit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q <= PadW'(mag);
      rem_q  <= '0;
      neg_q  <= raw[VALUE_BITS-1];
    end else if (cmd_i.div_step) begin
      work_q <= work_nx;
      rem_q  <= digit_done ? '0 : rem_nx;
      if (digit_done) begin
        stk_q[0] <= rem_nx;
        for (int i = 1; i < VALUE_BITS; i++) begin
          stk_q[i] <= stk_q[i-1];
        end
      end
    end else if (cmd_i.emit_digit) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stk_q[i] <= stk_q[i+1];
      end
    end
    if (cmd_i.emit_sign) begin
      out_sym_q  <= CHAR_MINUS;
      out_last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_sym_q  <= sym_tab_i[TAB_IDX_W'(stk_q[0])];
      out_last_q <= last_digit;
    end
  end

  assign sts_o.digit_done = digit_done;
  assign sts_o.quot_zero  = (work_nx == '0);
  assign sts_o.neg        = neg_q;
  assign sts_o.last_digit = last_digit;
  assign sts_o.slot_free  = slot_free;

  assign out_valid_o = out_valid_q;
  assign out_sym_o   = out_sym_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: design/srtt_chk.sv
// Port-level checker of the text converter and its bind to the top level.
`include "signed_radix_to_text_defines.svh"

module srtt_chk import srtt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [VAL_W-1:0] s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [SYM_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast,
  input logic             cfg_we_i,
  input logic [1:0]       cfg_idx_i,
  input logic [CFG_W-1:0] cfg_data_i
);

  `SRTT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  `SRTT_ASSERT_IMPL(a_busy_mid_number, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

  `SRTT_ASSERT_IMPL(a_sign_not_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata == CHAR_MINUS, !m_axis_tlast)

endmodule

bind signed_radix_to_text srtt_chk u_srtt_chk (.*);
